// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define RTPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RTPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rtpr_pkg.sv =====
// Package: constants, codes and shared types of the rolling token peer recogniser.
`default_nettype none

package rtpr_pkg;

    localparam int MAX_PEERS = 8;
    localparam int WINDOW    = 4;
    localparam int PEER_W    = $clog2(MAX_PEERS);
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);
    localparam int WIN_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int KEY_W     = 256;
    localparam int TOK_W     = 64;
    localparam int ROUNDS    = 64;
    localparam int RND_W     = $clog2(ROUNDS);

    localparam logic [31:0] TAG_TOKEN  = 32'h61757261;
    localparam logic [31:0] TAG_NEXT   = 32'h73746570;
    localparam logic [63:0] INNER_BITS = 64'd544;
    localparam logic [63:0] OUTER_BITS = 64'd768;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        OP_PAIR   = 2'd0,
        OP_REVOKE = 2'd1,
        OP_RECOG  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_FULL      = 3'd2,
        ST_REVOKED   = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TB_NONE   = 2'd0,
        TB_PAIR   = 2'd1,
        TB_REVOKE = 2'd2,
        TB_UPDATE = 2'd3
    } t_tbl;

    // Four compressions make one HMAC.
    typedef enum logic [1:0] {
        PH_KEY_IN  = 2'd0,
        PH_TAG     = 2'd1,
        PH_KEY_OUT = 2'd2,
        PH_OUTER   = 2'd3
    } t_phase;

    typedef struct packed {
        logic              capture;
        t_tbl              tbl;
        logic              key_load;
        logic              comp_start;
        t_phase            phase;
        logic              tag_next;
        logic [PEER_W-1:0] peer;
        logic [WIN_W-1:0]  win;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             tgt_ok;
        logic             peer_act;
        logic             comp_done;
        logic             match;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/rtpr_if.sv =====
// Interfaces: request channel and result channel.
`default_nettype none

interface rtpr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] key_w0;
    logic [63:0] key_w1;
    logic [63:0] key_w2;
    logic [63:0] key_w3;
    logic [7:0]  target_index;
    logic [63:0] token;

    modport source (output valid, op, key_w0, key_w1, key_w2, key_w3, target_index, token,
                    input ready);
    modport sink   (input valid, op, key_w0, key_w1, key_w2, key_w3, target_index, token,
                    output ready);
endinterface

interface rtpr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] found_index;
    logic [1:0] win_offset;

    modport source (output valid, status, found_index, win_offset, input ready);
    modport sink   (input valid, status, found_index, win_offset, output ready);
endinterface

`default_nettype wire

// ===== design/rtpr_datapath.sv =====
// Datapath: peer table, key memory and the SHA-256 round engine.
`default_nettype none
`include "assert_macros.svh"

module rtpr_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rtpr_pkg::t_cmd            i_cmd,
    input  logic [rtpr_pkg::KEY_W-1:0] i_key,
    input  logic [7:0]                i_target,
    input  logic [rtpr_pkg::TOK_W-1:0] i_token,
    output rtpr_pkg::t_stat           o_stat
);

    logic [rtpr_pkg::KEY_W-1:0] r_kmem [rtpr_pkg::MAX_PEERS];
    logic [rtpr_pkg::KEY_W-1:0] r_krd;
    logic [31:0]                r_epoch [rtpr_pkg::MAX_PEERS];
    logic [rtpr_pkg::MAX_PEERS-1:0] r_active;
    logic [rtpr_pkg::CNT_W-1:0] r_count;

    logic [rtpr_pkg::KEY_W-1:0] r_in_key;
    logic [7:0]                 r_tgt;
    logic [rtpr_pkg::TOK_W-1:0] r_tok;

    logic [rtpr_pkg::KEY_W-1:0] r_key;
    logic [255:0]               r_ih;
    logic                       r_match;

    logic [31:0]                r_h [8];
    logic [31:0]                r_v [8];
    logic [31:0]                r_w [16];
    logic [rtpr_pkg::RND_W-1:0] r_rnd;
    logic                       r_run;
    logic                       r_fin;

    logic [511:0] blk;
    logic [31:0]  h_base [8];
    logic [31:0]  h_sum [8];
    logic [255:0] digest;
    logic [31:0]  tag;
    logic [31:0]  t1, t2, w_new, sig0_a, sig1_e, ch, maj, ls0, ls1;
    logic [rtpr_pkg::PEER_W-1:0] wr_addr;
    logic [rtpr_pkg::KEY_W-1:0]  wr_data;
    logic                        wr_en;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Block words for the current compression
    always_comb begin
        tag = i_cmd.tag_next ? rtpr_pkg::TAG_NEXT : rtpr_pkg::TAG_TOKEN;
        case (i_cmd.phase)
            rtpr_pkg::PH_KEY_IN:  blk = {r_key ^ {32{8'h36}}, {32{8'h36}}};
            rtpr_pkg::PH_TAG:     blk = {tag, 32'h80000000, 384'b0, rtpr_pkg::INNER_BITS};
            rtpr_pkg::PH_KEY_OUT: blk = {r_key ^ {32{8'h5c}}, {32{8'h5c}}};
            default:              blk = {r_ih, 32'h80000000, 160'b0, rtpr_pkg::OUTER_BITS};
        endcase
        for (int i = 0; i < 8; i++) begin
            h_base[i] = (i_cmd.phase == rtpr_pkg::PH_KEY_IN || i_cmd.phase == rtpr_pkg::PH_KEY_OUT)
                        ? rtpr_pkg::INIT_H[i] : r_h[i];
            h_sum[i]  = r_h[i] + r_v[i];
        end
        digest = {h_sum[0], h_sum[1], h_sum[2], h_sum[3],
                  h_sum[4], h_sum[5], h_sum[6], h_sum[7]};
    end

    // One SHA-256 round
    always_comb begin
        sig1_e = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        sig0_a = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + sig1_e + ch + rtpr_pkg::ROUND_K[r_rnd] + r_w[0];
        t2     = sig0_a + maj;
        ls0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        ls1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new  = r_w[0] + ls0 + r_w[9] + ls1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_cmd.comp_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_rnd == rtpr_pkg::RND_W'(rtpr_pkg::ROUNDS - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= h_base[i];
                r_v[i] <= h_base[i];
            end
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= blk[511 - 32*i -: 32];
            end
        end else if (r_run) begin
            r_rnd <= r_rnd + 1'b1;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end else if (r_fin) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= h_sum[i];
            end
        end
    end

    // Capture the request fields; hold the inner hash, the token compare and the rolled key
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_key <= i_key;
            r_tgt    <= i_target;
            r_tok    <= i_token;
        end
        if (i_cmd.key_load) begin
            r_key <= r_krd;
        end else if (r_fin && i_cmd.phase == rtpr_pkg::PH_OUTER && i_cmd.tag_next) begin
            r_key <= digest;
        end
        if (r_fin && i_cmd.phase == rtpr_pkg::PH_TAG) begin
            r_ih <= digest;
        end
        if (r_fin && i_cmd.phase == rtpr_pkg::PH_OUTER && !i_cmd.tag_next) begin
            r_match <= (digest[255 -: rtpr_pkg::TOK_W] == r_tok);
        end
    end

    // Key memory: one write port, one registered read port
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = i_cmd.peer;
        wr_data = r_key;
        case (i_cmd.tbl)
            rtpr_pkg::TB_PAIR: begin
                wr_addr = r_count[rtpr_pkg::PEER_W-1:0];
                wr_data = r_in_key;
            end
            rtpr_pkg::TB_REVOKE: begin
                wr_addr = r_tgt[rtpr_pkg::PEER_W-1:0];
                wr_data = '0;
            end
            rtpr_pkg::TB_UPDATE: wr_data = r_key;
            default:             wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_kmem[wr_addr] <= wr_data;
        end
        r_krd <= r_kmem[i_cmd.peer];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl == rtpr_pkg::TB_PAIR) begin
            r_epoch[r_count[rtpr_pkg::PEER_W-1:0]] <= '0;
        end else if (i_cmd.tbl == rtpr_pkg::TB_UPDATE) begin
            r_epoch[i_cmd.peer] <= r_epoch[i_cmd.peer] + 32'(i_cmd.win) + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_count  <= '0;
        end else begin
            case (i_cmd.tbl)
                rtpr_pkg::TB_PAIR: begin
                    r_active[r_count[rtpr_pkg::PEER_W-1:0]] <= 1'b1;
                    r_count <= r_count + 1'b1;
                end
                rtpr_pkg::TB_REVOKE: r_active[r_tgt[rtpr_pkg::PEER_W-1:0]] <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_stat.count     = r_count;
    assign o_stat.tgt_ok    = (r_tgt < 8'(r_count));
    assign o_stat.peer_act  = r_active[i_cmd.peer];
    assign o_stat.comp_done = r_fin;
    assign o_stat.match     = r_match;

    `RTPR_ASSERT(a_start_idle, i_clk, i_rst_n, i_cmd.comp_start |-> (!r_run && !r_fin), "compression restarted while busy")
    `RTPR_ASSERT(a_fin_after_run, i_clk, i_rst_n, r_fin |-> $past(r_run), "finish without rounds")
    `RTPR_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= rtpr_pkg::CNT_W'(rtpr_pkg::MAX_PEERS), "peer count past table size")

endmodule

`default_nettype wire

// ===== design/rtpr_ctrl.sv =====
// Controller: sequences pairing, revocation and the HMAC scan over peers.
`default_nettype none
`include "assert_macros.svh"

module rtpr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_op,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [2:0]                 o_status,
    output logic [rtpr_pkg::CNT_W-1:0] o_found,
    output logic [1:0]                 o_ahead,
    output rtpr_pkg::t_cmd             o_cmd,
    input  rtpr_pkg::t_stat            i_stat
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_START  = 8'b0001_0000,
        S_WAIT   = 8'b0010_0000,
        S_STEP   = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    rtpr_pkg::t_op              r_op, n_op;
    logic [rtpr_pkg::CNT_W-1:0] r_peer, n_peer;
    logic [rtpr_pkg::WIN_W-1:0] r_win, n_win;
    logic                       r_tag, n_tag;
    rtpr_pkg::t_phase           r_phase, n_phase;
    logic                       r_any, n_any;
    rtpr_pkg::t_status          r_status, n_status;
    logic [rtpr_pkg::CNT_W-1:0] r_found, n_found;
    logic [1:0]                 r_ahead, n_ahead;
    logic                       r_out_valid, n_out_valid;
    logic [2:0]                 r_o_status, n_o_status;
    logic [rtpr_pkg::CNT_W-1:0] r_o_found, n_o_found;
    logic [1:0]                 r_o_ahead, n_o_ahead;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_peer      = r_peer;
        n_win       = r_win;
        n_tag       = r_tag;
        n_phase     = r_phase;
        n_any       = r_any;
        n_status    = r_status;
        n_found     = r_found;
        n_ahead     = r_ahead;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_found   = r_o_found;
        n_o_ahead   = r_o_ahead;

        o_cmd            = '0;
        o_cmd.tbl        = rtpr_pkg::TB_NONE;
        o_cmd.phase      = r_phase;
        o_cmd.tag_next   = r_tag;
        o_cmd.peer       = r_peer[rtpr_pkg::PEER_W-1:0];
        o_cmd.win        = r_win;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = rtpr_pkg::t_op'(i_op);
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_RESULT;
                n_found  = rtpr_pkg::CNT_W'(rtpr_pkg::MAX_PEERS);
                n_ahead  = '0;
                n_status = rtpr_pkg::ST_BAD_INDEX;
                case (r_op)
                    rtpr_pkg::OP_PAIR: begin
                        if (i_stat.count >= rtpr_pkg::CNT_W'(rtpr_pkg::MAX_PEERS)) begin
                            n_status = rtpr_pkg::ST_FULL;
                        end else begin
                            o_cmd.tbl = rtpr_pkg::TB_PAIR;
                            n_status  = rtpr_pkg::ST_OK;
                            n_found   = i_stat.count;
                        end
                    end
                    rtpr_pkg::OP_REVOKE: begin
                        if (i_stat.tgt_ok) begin
                            o_cmd.tbl = rtpr_pkg::TB_REVOKE;
                            n_status  = rtpr_pkg::ST_OK;
                        end
                    end
                    rtpr_pkg::OP_RECOG: begin
                        n_peer  = '0;
                        n_any   = 1'b0;
                        n_state = S_SCAN;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (r_peer >= i_stat.count) begin
                    n_status = (!r_any && i_stat.count != '0) ? rtpr_pkg::ST_REVOKED
                                                              : rtpr_pkg::ST_UNKNOWN;
                    n_found  = rtpr_pkg::CNT_W'(rtpr_pkg::MAX_PEERS);
                    n_ahead  = '0;
                    n_state  = S_RESULT;
                end else if (!i_stat.peer_act) begin
                    n_peer = r_peer + 1'b1;
                end else begin
                    n_any   = 1'b1;
                    n_win   = '0;
                    n_tag   = 1'b0;
                    n_phase = rtpr_pkg::PH_KEY_IN;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.key_load = 1'b1;
                n_state        = S_START;
            end
            S_START: begin
                o_cmd.comp_start = 1'b1;
                n_state          = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.comp_done) begin
                    n_state = S_START;
                    case (r_phase)
                        rtpr_pkg::PH_KEY_IN:  n_phase = rtpr_pkg::PH_TAG;
                        rtpr_pkg::PH_TAG:     n_phase = rtpr_pkg::PH_KEY_OUT;
                        rtpr_pkg::PH_KEY_OUT: n_phase = rtpr_pkg::PH_OUTER;
                        default:              n_state = S_STEP;
                    endcase
                end
            end
            S_STEP: begin
                n_phase = rtpr_pkg::PH_KEY_IN;
                if (!r_tag) begin
                    // token checked, now roll the key
                    n_tag   = 1'b1;
                    n_state = S_START;
                end else if (i_stat.match) begin
                    o_cmd.tbl = rtpr_pkg::TB_UPDATE;
                    n_status  = rtpr_pkg::ST_OK;
                    n_found   = r_peer;
                    n_ahead   = 2'(r_win);
                    n_state   = S_RESULT;
                end else if (r_win == rtpr_pkg::WIN_W'(rtpr_pkg::WINDOW - 1)) begin
                    n_peer  = r_peer + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_win   = r_win + 1'b1;
                    n_tag   = 1'b0;
                    n_state = S_START;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_found   = r_found;
                    n_o_ahead   = r_ahead;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_peer     <= n_peer;
        r_win      <= n_win;
        r_tag      <= n_tag;
        r_phase    <= n_phase;
        r_any      <= n_any;
        r_status   <= n_status;
        r_found    <= n_found;
        r_ahead    <= n_ahead;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_ahead  <= n_o_ahead;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_found     = r_o_found;
    assign o_ahead     = r_o_ahead;

    `RTPR_ASSERT(a_accept_decode, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_DECODE), "accepted word not decoded")
    `RTPR_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_peer <= i_stat.count), "scan ran past the table")
    `RTPR_ASSERT(a_ok_found, i_clk, i_rst_n, (r_state == S_RESULT && r_status == rtpr_pkg::ST_OK && r_op != rtpr_pkg::OP_REVOKE) |-> (r_found < i_stat.count), "reported slot not in table")

endmodule

`default_nettype wire

// ===== design/rolling_token_peer_recognizer.sv =====
// Rolling token peer recogniser: usage.
// Request channel i_in carries op, a 32-byte pairing key, a revoke slot and a token.
// Result channel o_out returns status, found_index and win_offset, one word per request.
// Pair and revoke: the request passes the decode and result states, and the result
// word turns valid as the controller returns to idle, ready for the next request.
// Recognise walks the active peers in slot order; each window step computes two
// HMAC-SHA256 values of four compressions each, one round per cycle on a single
// shared round engine. The worst case is 8 peers with 4 steps each and no match;
// a match ends the scan.
// Requests are taken one at a time, only when the controller is idle.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and worked on, and waits only to hand over its result.
// Reset (synchronous, active low) empties the peer table and drops any pending result.
`default_nettype none

module rolling_token_peer_recognizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtpr_in_if.sink    i_in,
    rtpr_out_if.source o_out
);

    rtpr_pkg::t_cmd             cmd;
    rtpr_pkg::t_stat            stat;
    logic [rtpr_pkg::CNT_W-1:0] found;

    rtpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (o_out.status),
        .o_found     (found),
        .o_ahead     (o_out.win_offset),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    assign o_out.found_index = 4'(found);

    rtpr_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_key    ({i_in.key_w0, i_in.key_w1, i_in.key_w2, i_in.key_w3}),
        .i_target (i_in.target_index),
        .i_token  (i_in.token),
        .o_stat   (stat)
    );

endmodule

`default_nettype wire
